/* sv/baseline_payload_anomaly_detector_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef BASELINE_PAYLOAD_ANOMALY_DETECTOR_UNIT_DEFINES_SVH
`define BASELINE_PAYLOAD_ANOMALY_DETECTOR_UNIT_DEFINES_SVH

// Clocked property with reset disable.
`define BPAD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication with reset disable.
`define BPAD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* sv/bpad_pkg.sv */
`default_nettype none
package bpad_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned BaselineCountDef = 10;
	localparam int unsigned BufferBytesDef   = 16;

	// Fixed geometry set by the 16-bit fault masks
	localparam int unsigned Positions = 16;
	localparam int unsigned PosW      = 4;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned StepW     = 9;

	typedef logic [PosW-1:0]  pos_t;
	typedef logic [ByteW-1:0] byte_t;

	// One memory entry per byte position
	typedef struct packed {
		byte_t                   first;
		logic signed [StepW-1:0] step;
		byte_t                   prev;
		logic                    changed;
		logic                    not_counter;
	} entry_t;

	// Memory access; one address serves read and write, never both at once
	typedef struct packed {
		logic   rd;
		logic   wr;
		pos_t   addr;
		entry_t wdata;
	} mem_req_t;

	// Remainder unit control and status
	typedef struct packed {
		logic  start;
		byte_t dividend;
		byte_t divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic rem_nonzero;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

/* sv/baseline_payload_anomaly_detector_unit.sv */
`default_nettype none
// Channel   Dir  Handshake                  Fields
// data      in   data_valid / data_stall    data_byte
// result    out  result_valid / result_stall learning, anomaly,
//                                           static_fault_mask, counter_fault_mask
//
// A byte passes the accept, evaluate and finish states; a checked counter position
// adds a remainder state of 8 bit-serial steps between evaluate and finish.
// Per-position state sits in a 16-entry memory with a registered read; one byte
// is in flight at a time, so read-modify-write of an entry never overlaps.
// Reset clears control state and accumulators; no clearing pass is run.
// The last byte of a buffer waits in the finish cycle while a result is held
// under result_stall; other bytes proceed regardless.
module baseline_payload_anomaly_detector_unit import bpad_pkg::*; #(
	parameter int unsigned BASELINE_COUNT = BaselineCountDef,
	parameter int unsigned BUFFER_BYTES   = BufferBytesDef
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 data_valid,
	output logic                      data_stall,
	input  wire logic [ByteW-1:0]     data_byte,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      learning,
	output logic                      anomaly,
	output logic [Positions-1:0]      static_fault_mask,
	output logic [Positions-1:0]      counter_fault_mask
);

	localparam pos_t     LastPos = pos_t'(BUFFER_BYTES - 1);
	localparam pos_t     BaseCnt = pos_t'(BASELINE_COUNT);
	localparam pos_t     SeenOne = pos_t'(1);

	function automatic byte_t mag9(input logic signed [StepW-1:0] v);
		logic [StepW-1:0] n;
		n = -v;
		return v[StepW-1] ? n[ByteW-1:0] : v[ByteW-1:0];
	endfunction

	state_t state_q, state_d;

	pos_t                 pos_q;
	pos_t                 seen_q;
	byte_t                byte_q;
	logic [Positions-1:0] sacc_q;
	logic [Positions-1:0] cacc_q;
	logic                 out_valid_q;
	logic                 learning_q;
	logic                 anomaly_q;
	logic [Positions-1:0] smask_q;
	logic [Positions-1:0] cmask_q;

	mem_req_t mreq;
	entry_t   rd;
	entry_t   wd;
	div_req_t dreq;
	div_rsp_t drsp;

	logic                    accept;
	logic                    is_learning;
	logic                    is_last;
	logic                    out_free;
	logic                    load_out;
	logic [Positions-1:0]    pos_bit;
	logic signed [StepW-1:0] diff_first;
	logic signed [StepW-1:0] diff_prev;
	logic                    ne_first;
	logic                    static_hit;
	logic                    counter_cand;

	bpad_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rd)
	);

	bpad_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign is_learning = (seen_q < BaseCnt);
	assign is_last     = (pos_q == LastPos);
	assign out_free    = !out_valid_q || !result_stall;
	assign pos_bit     = {{(Positions-1){1'b0}}, 1'b1} << pos_q;

	// Evaluate the held byte against its entry
	always_comb begin
		diff_first   = $signed({1'b0, byte_q}) - $signed({1'b0, rd.first});
		diff_prev    = $signed({1'b0, byte_q}) - $signed({1'b0, rd.prev});
		ne_first     = (byte_q != rd.first);
		static_hit   = !rd.changed && ne_first;
		counter_cand = !rd.not_counter && (rd.step != '0);

		wd      = rd;
		wd.prev = byte_q;
		if (seen_q == '0) begin
			wd.first       = byte_q;
			wd.changed     = 1'b0;
			wd.not_counter = 1'b0;
		end else if (seen_q == SeenOne) begin
			wd.step        = diff_first;
			wd.changed     = rd.changed | ne_first;
			wd.not_counter = rd.not_counter | (diff_first == '0);
		end else begin
			wd.changed     = rd.changed | ne_first;
			wd.not_counter = rd.not_counter | (diff_prev != rd.step);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (data_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!is_learning && counter_cand) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (!drsp.busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!is_last || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs per state
	always_comb begin
		data_stall    = 1'b1;
		accept        = 1'b0;
		load_out      = 1'b0;
		mreq.rd       = 1'b0;
		mreq.wr       = 1'b0;
		mreq.addr     = pos_q;
		mreq.wdata    = wd;
		dreq.start    = 1'b0;
		dreq.dividend = mag9(diff_first);
		dreq.divisor  = mag9(rd.step);
		case (state_q)
			ST_IDLE: begin
				data_stall = 1'b0;
				accept     = data_valid;
				mreq.rd    = data_valid;
			end
			ST_EVAL: begin
				mreq.wr    = is_learning;
				dreq.start = !is_learning && counter_cand;
			end
			ST_DIV: begin
			end
			ST_FIN: begin
				load_out = is_last && out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
		end
	end

	// Advance position and baseline count, accumulate faults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= '0;
			sacc_q <= '0;
			cacc_q <= '0;
		end else begin
			if (state_q == ST_EVAL && !is_learning && static_hit) begin
				sacc_q <= sacc_q | pos_bit;
			end
			if (state_q == ST_DIV && !drsp.busy && drsp.rem_nonzero) begin
				cacc_q <= cacc_q | pos_bit;
			end
			if (state_q == ST_FIN && !is_last) begin
				pos_q <= pos_q + 1'b1;
			end
			if (load_out) begin
				pos_q  <= '0;
				sacc_q <= '0;
				cacc_q <= '0;
				if (is_learning) begin
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	// Result word register; accumulators stay clear while learning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			learning_q <= is_learning;
			anomaly_q  <= |(sacc_q | cacc_q);
			smask_q    <= sacc_q;
			cmask_q    <= cacc_q;
		end
	end

	assign result_valid       = out_valid_q;
	assign learning           = learning_q;
	assign anomaly            = anomaly_q;
	assign static_fault_mask  = smask_q;
	assign counter_fault_mask = cmask_q;

endmodule
`default_nettype wire

/* sv/bpad_mem.sv */
`default_nettype none
module bpad_mem import bpad_pkg::*; (
	input  wire logic     clk,
	input  wire mem_req_t req,
	output entry_t        rdata
);

	entry_t mem [Positions];
	entry_t rdata_q;

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* sv/bpad_rem.sv */
`default_nettype none
module bpad_rem import bpad_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int unsigned CntW = $clog2(ByteW);
	localparam logic [CntW-1:0] LastCnt = CntW'(ByteW - 1);

	logic            busy_q;
	logic [CntW-1:0] cnt_q;
	byte_t           rem_q;
	byte_t           dvd_q;
	byte_t           dsr_q;
	logic [ByteW:0]  trial;
	logic [ByteW:0]  rem_next;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[ByteW-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = trial - {1'b0, dsr_q};
		end else begin
			rem_next = trial;
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LastCnt) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operands and partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next[ByteW-1:0];
			dvd_q <= {dvd_q[ByteW-2:0], 1'b0};
		end
	end

	assign rsp.busy        = busy_q;
	assign rsp.rem_nonzero = (rem_q != '0);

endmodule
`default_nettype wire

/* sv/bpad_checker.sv */
`default_nettype none
`include "baseline_payload_anomaly_detector_unit_defines.svh"
module bpad_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        data_valid,
	input wire logic        data_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic        learning,
	input wire logic        anomaly,
	input wire logic [15:0] static_fault_mask,
	input wire logic [15:0] counter_fault_mask
);

	// A held result word stays offered
	`BPAD_ASSERT(a_result_hold, clk, arst_n, (result_valid && result_stall) |=> result_valid, "result word dropped under stall")

	// A learning word carries no faults
	`BPAD_ASSERT_IMP(a_learn_clean, clk, arst_n, result_valid && learning, !anomaly && (static_fault_mask == 16'h0) && (counter_fault_mask == 16'h0), "fault reported on learning word")

	// The anomaly flag summarizes both masks
	`BPAD_ASSERT_IMP(a_anomaly_sum, clk, arst_n, result_valid, anomaly == ((static_fault_mask | counter_fault_mask) != 16'h0), "anomaly flag disagrees with masks")

	// One byte in flight: stall right after each accepted byte
	`BPAD_ASSERT(a_busy_after_accept, clk, arst_n, (data_valid && !data_stall) |=> data_stall, "input taken while a byte is in flight")

endmodule

bind baseline_payload_anomaly_detector_unit bpad_checker u_bpad_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.data_valid         (data_valid),
	.data_stall         (data_stall),
	.result_valid       (result_valid),
	.result_stall       (result_stall),
	.learning           (learning),
	.anomaly            (anomaly),
	.static_fault_mask  (static_fault_mask),
	.counter_fault_mask (counter_fault_mask)
);
`default_nettype wire
